[rtl/core/crc16fr_pkg.sv]
package crc16fr_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 256;
  localparam int unsigned PayloadAddrW  = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned PaddrW        = 3;

  localparam logic [7:0]  SofByte  = 8'hA5;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcTop   = 16'h8000;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [7:0]  VerReset = 8'h01;

  localparam logic [PaddrW-3:0] RegProtoVersion = '0;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((r & CrcTop) != 16'h0000) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/crc16_frame_receiver.sv]
// Byte-serial frame receiver. Each input transaction either feeds one link byte (action_i = 0)
// or reads one stored payload byte (action_i = 1) and yields exactly one result transaction.
// A frame is 0xA5, version, type, length, payload, then the CRC-16/CCITT-FALSE low and high
// bytes taken over version, type, length and payload. Stray bytes while hunting and bad versions
// increment resync_count_o; a CRC mismatch increments crc_error_count_o; both wrap. The
// result of the final CRC byte carries frame_done_o, frame_ok_o, type and length. The payload
// lies in a 256 x 8 synchronous RAM with a registered read; a byte is written as it arrives and
// a read action returns the byte in the output register in the next cycle. One transaction is
// taken every clock cycle; the block stalls only while a result waits.
// The RAM holds nothing after reset: reading a position not written since reset returns an
// arbitrary value. The version register (byte address 0, reset 1) is written over the APB port.
module crc16_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crc16fr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [7:0]                     read_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           frame_done_o,
  output logic                           frame_ok_o,
  output logic [7:0]                     frame_type_o,
  output logic [7:0]                     frame_length_o,
  output logic [31:0]                    resync_count_o,
  output logic [31:0]                    crc_error_count_o,
  output logic [7:0]                     read_data_o
);
  import crc16fr_pkg::*;

  localparam logic [2:0] PhSof     = 3'd0;
  localparam logic [2:0] PhVer     = 3'd1;
  localparam logic [2:0] PhType    = 3'd2;
  localparam logic [2:0] PhLen     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;
  localparam logic [2:0] PhCrcHi   = 3'd6;

  logic [7:0]  ver_q;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [31:0] resync_q, resync_d;
  logic [31:0] crc_err_q, crc_err_d;

  logic        out_valid_q;
  logic        done_q, done_d;
  logic        ok_q, ok_d;
  logic [7:0]  ftype_q, ftype_d;
  logic [7:0]  flen_q, flen_d;
  logic        rd_ok_q;
  logic [7:0]  rd_q;

  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic        mem_we;
  logic        rd_en;
  logic        rd_in_range;
  logic        accept;
  logic        feed;
  logic [7:0]  cnt_inc;

  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1:2] == RegProtoVersion) ? {24'h000000, ver_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= VerReset;
    end else if (psel && penable && pwrite && (paddr[PaddrW-1:2] == RegProtoVersion)) begin
      ver_q <= pwdata[7:0];
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign feed        = accept && !action_i;
  assign rd_in_range = {1'b0, read_index_i} < 9'(PAYLOAD_DEPTH);
  assign rd_en       = accept && action_i;
  assign cnt_inc     = cnt_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    resync_d  = resync_q;
    crc_err_d = crc_err_q;
    done_d    = 1'b0;
    ok_d      = 1'b0;
    ftype_d   = 8'h00;
    flen_d    = 8'h00;
    mem_we    = 1'b0;
    if (feed) begin
      case (phase_q)
        PhVer: begin
          if (data_byte_i == ver_q) begin
            crc_d   = crc16_upd(CrcInit, data_byte_i);
            phase_d = PhType;
          end else begin
            resync_d = resync_q + 32'd1;
            phase_d  = PhSof;
          end
        end
        PhType: begin
          type_d  = data_byte_i;
          crc_d   = crc16_upd(crc_q, data_byte_i);
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = data_byte_i;
          cnt_d   = 8'h00;
          crc_d   = crc16_upd(crc_q, data_byte_i);
          phase_d = (data_byte_i != 8'h00) ? PhPayload : PhCrcLo;
        end
        PhPayload: begin
          mem_we = {1'b0, cnt_q} < 9'(PAYLOAD_DEPTH);
          cnt_d  = cnt_inc;
          crc_d  = crc16_upd(crc_q, data_byte_i);
          if (cnt_inc >= len_q) begin
            phase_d = PhCrcLo;
          end
        end
        PhCrcLo: begin
          crc_lo_d = data_byte_i;
          phase_d  = PhCrcHi;
        end
        PhCrcHi: begin
          done_d  = 1'b1;
          ftype_d = type_q;
          flen_d  = len_q;
          if ({data_byte_i, crc_lo_q} == crc_q) begin
            ok_d = 1'b1;
          end else begin
            crc_err_d = crc_err_q + 32'd1;
          end
          phase_d = PhSof;
        end
        default: begin
          if (data_byte_i == SofByte) begin
            phase_d = PhVer;
          end else begin
            resync_d = resync_q + 32'd1;
            phase_d  = PhSof;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSof;
      type_q    <= 8'h00;
      len_q     <= 8'h00;
      cnt_q     <= 8'h00;
      crc_q     <= CrcInit;
      crc_lo_q  <= 8'h00;
      resync_q  <= 32'h0;
      crc_err_q <= 32'h0;
    end else begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      crc_lo_q  <= crc_lo_d;
      resync_q  <= resync_d;
      crc_err_q <= crc_err_d;
    end
  end

  // payload ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[PayloadAddrW-1:0]] <= data_byte_i;
    end
    if (rd_en) begin
      rd_q <= mem[read_index_i[PayloadAddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      ok_q        <= 1'b0;
      ftype_q     <= 8'h00;
      flen_q      <= 8'h00;
      rd_ok_q     <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      done_q      <= done_d;
      ok_q        <= ok_d;
      ftype_q     <= ftype_d;
      flen_q      <= flen_d;
      rd_ok_q     <= action_i && rd_in_range;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_done_o      = done_q;
  assign frame_ok_o        = ok_q;
  assign frame_type_o      = ftype_q;
  assign frame_length_o    = flen_q;
  assign resync_count_o    = resync_q;
  assign crc_error_count_o = crc_err_q;
  assign read_data_o       = rd_ok_q ? rd_q : 8'h00;

endmodule

[rtl/core/crc16fr_checker.sv]
module crc16fr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        frame_done_o,
  input logic        frame_ok_o,
  input logic [7:0]  frame_type_o,
  input logic [7:0]  frame_length_o,
  input logic [31:0] resync_count_o,
  input logic [31:0] crc_error_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o |-> frame_done_o)
    else $error("frame ok without frame done");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_type_o == 8'h00 && frame_length_o == 8'h00)
    else $error("frame fields set without frame done");

  a_resync_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(resync_count_o) || resync_count_o == $past(resync_count_o) + 32'd1)
    else $error("resync count jumped");

  a_crc_err_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(crc_error_count_o) || crc_error_count_o == $past(crc_error_count_o) + 32'd1)
    else $error("crc error count jumped");

endmodule

bind crc16_frame_receiver crc16fr_checker u_crc16fr_checker (.*);
